[sv/psrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_pkg
// shared types, constants and codes of the srrip / lru replacement block
// ----------------------------------------------------------------------------
package psrl_pkg;

    // default geometry
    localparam int NUM_SETS_DEF  = 2048;
    localparam int NUM_WAYS_DEF  = 16;
    localparam int RRPV_BITS_DEF = 2;

    // fixed field widths
    localparam int SET_IN_W   = 11;
    localparam int ADDR_W     = 48;
    localparam int STRIDE_W   = 49;
    localparam int CNT_W      = 16;
    localparam int THR_W      = 8;
    localparam int WARM_W     = 3;
    localparam int PTR_W      = 2;
    localparam int HIST_LEN   = 4;
    localparam int STRIDE_LEN = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WARM_W-1:0] WARM_MAX = 3'd5;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // configuration reset values
    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd512;
    localparam logic [CNT_W-1:0] TOL_RST    = 16'd64;
    localparam logic [THR_W-1:0] THR_RST    = 8'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_THR      = 2'd2;

    // command and mode codes
    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;
    localparam logic MODE_SRRIP = 1'b0;
    localparam logic MODE_LRU   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_MOD,
        ST_EXEC1,
        ST_EXEC2,
        ST_EXEC3,
        ST_WRITE
    } state_t;

    // per-set statistics and history, one memory row
    typedef struct packed {
        logic                                   mode;
        logic [WARM_W-1:0]                      warm;
        logic [CNT_W-1:0]                       pcount;
        logic [CNT_W-1:0]                       phits;
        logic [PTR_W-1:0]                       ptr;
        logic [HIST_LEN-1:0][ADDR_W-1:0]        hist;
        logic [STRIDE_LEN-1:0][STRIDE_W-1:0]    stride;
    } set_stats_t;

    localparam int STATS_W = $bits(set_stats_t);

    typedef struct packed {
        logic clear_we;
        logic accept;
        logic quot;
        logic rd;
        logic exec1;
        logic exec2;
        logic exec3;
        logic write;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

[sv/phase_adaptive_srrip_lru_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_adaptive_srrip_lru_replacement
// per-set replacement policy switching each set between srrip and lru
// ----------------------------------------------------------------------------
// sequence: one item at a time; a new request is taken only after the last
//   one is written back, as the block does the read-modify-write of the
//   set row in the metadata memories (index reduce, read, three steps, write)
// reset: after rst_n the block clears NUM_SETS memory rows, one per cycle,
//   with in_stall high; configuration writes are taken during that pass
// ----------------------------------------------------------------------------
module phase_adaptive_srrip_lru_replacement #(
    parameter int NUM_SETS  = psrl_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = psrl_pkg::NUM_WAYS_DEF,
    parameter int RRPV_BITS = psrl_pkg::RRPV_BITS_DEF,
    localparam int WAY_W = $clog2(NUM_WAYS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [psrl_pkg::SET_IN_W-1:0]    set_index,
    input  logic [WAY_W-1:0]                 way_index,
    input  logic [psrl_pkg::ADDR_W-1:0]      phys_addr,
    input  logic                             was_hit,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [WAY_W-1:0]                 victim_way,
    output logic                             set_mode,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psrl_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // registers can always take a transfer; write them only while the block is idle (not enforced by the block)
    assign cfg_ready = 1'b1;

    // sequencer: clearing pass, then one item at a time through the datapath
    psrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    // datapath: set reduction, metadata memories, victim search, update
    psrl_dp #(
        .NUM_SETS  (NUM_SETS),
        .NUM_WAYS  (NUM_WAYS),
        .RRPV_BITS (RRPV_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .cmd        (cmd),
        .set_index  (set_index),
        .way_index  (way_index),
        .phys_addr  (phys_addr),
        .was_hit    (was_hit),
        .cfg_valid  (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .victim_way (victim_way),
        .set_mode   (set_mode)
    );

endmodule

[sv/psrl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/psrl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_ctrl
// sequencer: clearing pass, item steps and output register handshake
// ----------------------------------------------------------------------------
module psrl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output psrl_pkg::dp_cmd_t    dp_cmd,
    input  psrl_pkg::dp_status_t dp_status
);
    import psrl_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dp_cmd.clear_we = 1'b1;
                if (dp_status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    state_next    = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                dp_cmd.quot = 1'b1;
                state_next  = ST_MOD;
            end
            ST_MOD:
            begin
                dp_cmd.rd  = 1'b1;
                state_next = ST_EXEC1;
            end
            ST_EXEC1:
            begin
                dp_cmd.exec1 = 1'b1;
                state_next   = ST_EXEC2;
            end
            ST_EXEC2:
            begin
                dp_cmd.exec2 = 1'b1;
                state_next   = ST_EXEC3;
            end
            ST_EXEC3:
            begin
                dp_cmd.exec3 = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                // wait while the previous result is still held
                if (!(out_valid_reg && out_stall))
                begin
                    dp_cmd.write = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (dp_cmd.write)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/psrl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_dp
// datapath: set reduction, metadata memories, victim search and update
// ----------------------------------------------------------------------------
module psrl_dp #(
    parameter int NUM_SETS  = psrl_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = psrl_pkg::NUM_WAYS_DEF,
    parameter int RRPV_BITS = psrl_pkg::RRPV_BITS_DEF,
    localparam int WAY_W = $clog2(NUM_WAYS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  psrl_pkg::dp_cmd_t                dp_cmd,
    output psrl_pkg::dp_status_t             dp_status,
    input  logic                             cmd,
    input  logic [psrl_pkg::SET_IN_W-1:0]    set_index,
    input  logic [WAY_W-1:0]                 way_index,
    input  logic [psrl_pkg::ADDR_W-1:0]      phys_addr,
    input  logic                             was_hit,
    input  logic                             cfg_valid,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [WAY_W-1:0]                 victim_way,
    output logic                             set_mode
);
    import psrl_pkg::*;

    localparam int SIDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int AGE_W  = WAY_W;
    localparam int NVAL   = 1 << RRPV_BITS;
    localparam int NAGE   = 1 << AGE_W;
    localparam int RCP_SH = 28;
    localparam int RCP_W  = 29;
    localparam int NS_W   = 17;
    localparam int QP_W   = SET_IN_W + RCP_W;
    localparam int QN_W   = SET_IN_W + NS_W;
    localparam int D_W    = STRIDE_W + 1;
    localparam int PR_W   = CNT_W + THR_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
    localparam logic [QN_W-1:0]      NSETS    = QN_W'(NUM_SETS);
    localparam logic [SIDX_W-1:0]    LAST_SET = SIDX_W'(NUM_SETS - 1);
    localparam logic [RRPV_BITS-1:0] RR_TOP   = '1;
    localparam logic [RRPV_BITS-1:0] RR_FILL  = RR_TOP - 1'b1;
    localparam logic [AGE_W-1:0]     AGE_MAX  = AGE_W'(NUM_WAYS - 1);
    localparam logic [WAY_W:0]       WAYS     = (WAY_W + 1)'(NUM_WAYS);

    typedef logic [NUM_WAYS-1:0][RRPV_BITS-1:0] rr_row_t;
    typedef logic [NUM_WAYS-1:0][AGE_W-1:0]     ag_row_t;

    // configuration
    logic [CNT_W-1:0] period_reg, tol_reg;
    logic [THR_W-1:0] thr_reg;

    // captured item
    logic                cmd_reg, hit_reg;
    logic [SET_IN_W-1:0] set_in_reg, q_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [SIDX_W-1:0]   set_reg, clr_cnt_reg;

    // working copy of the set
    rr_row_t    rr_reg, rr_rd, rr_rst, rr_aged, rr_new;
    ag_row_t    ag_reg, ag_rd, ag_rst, ag_new;
    set_stats_t st_reg, st_rd, st_upd, st_new;

    logic [RRPV_BITS-1:0] m_rr_reg, m_rr;
    logic [AGE_W-1:0]     m_ag_reg, m_ag;
    logic [WAY_W-1:0]     victim_reg, out_victim_reg, srrip_v, lru_v;
    logic                 out_mode_reg, spatial_reg, spatial_next, found;
    logic [PR_W-1:0]      prod_reg, prod_next;

    logic [QP_W-1:0]   qprod;
    logic [QN_W-1:0]   qn, r0, r1;
    logic [SIDX_W-1:0] set_mod;

    logic              we;
    logic [SIDX_W-1:0] waddr;

    // set index reduction: reciprocal multiply, then one correction
    assign qprod   = QP_W'(set_in_reg) * QP_W'(RCP);
    assign qn      = QN_W'(q_reg) * NSETS;
    assign r0      = QN_W'(set_in_reg) - qn;
    assign r1      = (r0 >= NSETS) ? r0 - NSETS : r0;
    assign set_mod = r1[SIDX_W-1:0];

    // memories
    assign we    = dp_cmd.clear_we | dp_cmd.write;
    assign waddr = dp_cmd.clear_we ? clr_cnt_reg : set_reg;

    always_comb
    begin
        rr_rst = '1;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            ag_rst[w] = AGE_W'(w);
        end
    end

    psrl_ram #(.WIDTH(NUM_WAYS * RRPV_BITS), .DEPTH(NUM_SETS)) u_rr_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (dp_cmd.clear_we ? rr_rst : rr_reg),
        .re    (dp_cmd.rd),
        .raddr (set_mod),
        .rdata (rr_rd)
    );

    psrl_ram #(.WIDTH(NUM_WAYS * AGE_W), .DEPTH(NUM_SETS)) u_ag_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (dp_cmd.clear_we ? ag_rst : ag_reg),
        .re    (dp_cmd.rd),
        .raddr (set_mod),
        .rdata (ag_rd)
    );

    psrl_ram #(.WIDTH(STATS_W), .DEPTH(NUM_SETS)) u_st_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (dp_cmd.clear_we ? set_stats_t'('0) : st_reg),
        .re    (dp_cmd.rd),
        .raddr (set_mod),
        .rdata (st_rd)
    );

    assign dp_status.clear_last = (clr_cnt_reg == LAST_SET);

    // first step: counters, history, strides and maxima
    always_comb
    begin
        logic [PTR_W-1:0]    p;
        logic [STRIDE_W-1:0] stride;
        logic [NVAL-1:0]     rr_pres;
        logic [NAGE-1:0]     ag_pres;
        st_upd  = st_rd;
        p       = st_rd.ptr;
        stride  = {1'b0, addr_reg} - {1'b0, st_rd.hist[p]};
        rr_pres = '0;
        ag_pres = '0;
        m_rr    = '0;
        m_ag    = '0;
        if (st_rd.warm < WARM_MAX)
        begin
            st_upd.warm = st_rd.warm + 1'b1;
        end
        if (st_rd.pcount != CNT_MAX)
        begin
            st_upd.pcount = st_rd.pcount + 1'b1;
        end
        if (hit_reg && st_rd.phits != CNT_MAX)
        begin
            st_upd.phits = st_rd.phits + 1'b1;
        end
        if (p != '0)
        begin
            st_upd.stride[p - 1'b1] = stride;
        end
        st_upd.hist[p] = addr_reg;
        st_upd.ptr     = p + 1'b1;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            rr_pres[rr_rd[w]] = 1'b1;
            ag_pres[ag_rd[w]] = 1'b1;
        end
        for (int v = 0; v < NVAL; v++)
        begin
            if (rr_pres[v])
            begin
                m_rr = RRPV_BITS'(v);
            end
        end
        for (int v = 0; v < NAGE; v++)
        begin
            if (ag_pres[v])
            begin
                m_ag = AGE_W'(v);
            end
        end
    end

    // second step: victim choice, stride consistency, rate product
    always_comb
    begin
        logic [RRPV_BITS:0] delta, add;
        logic [D_W-1:0]     d, mag;
        logic               bad;
        delta   = {1'b0, RR_TOP} - {1'b0, m_rr_reg};
        add     = (delta > (RRPV_BITS + 1)'(2)) ? (RRPV_BITS + 1)'(2) : delta;
        found   = (delta <= (RRPV_BITS + 1)'(1));
        srrip_v = '0;
        lru_v   = '0;
        bad     = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            rr_aged[w] = RRPV_BITS'({1'b0, rr_reg[w]} + add);
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (rr_aged[w] == RR_TOP)
            begin
                srrip_v = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (ag_reg[w] == m_ag_reg)
            begin
                lru_v = WAY_W'(w);
            end
        end
        for (int i = 0; i < STRIDE_LEN; i++)
        begin
            d   = {st_reg.stride[i][STRIDE_W-1], st_reg.stride[i]}
                - {st_reg.stride[0][STRIDE_W-1], st_reg.stride[0]};
            mag = d[D_W-1] ? -d : d;
            if (mag > D_W'(tol_reg))
            begin
                bad = 1'b1;
            end
        end
        spatial_next = (st_reg.warm == WARM_MAX) && !bad;
        prod_next    = PR_W'(thr_reg) * PR_W'(st_reg.pcount);
    end

    // third step: mode re-evaluation and line promotion or insertion
    always_comb
    begin
        logic             reeval;
        logic [PR_W-1:0]  lhs;
        logic [AGE_W-1:0] old;
        st_new = st_reg;
        rr_new = rr_reg;
        ag_new = ag_reg;
        reeval = (st_reg.pcount >= period_reg);
        lhs    = {st_reg.phits, {THR_W{1'b0}}};
        old    = '0;
        if (reeval)
        begin
            st_new.mode   = (spatial_reg && lhs > prod_reg) ? MODE_SRRIP : MODE_LRU;
            st_new.pcount = '0;
            st_new.phits  = '0;
        end
        if ({1'b0, way_reg} < WAYS)
        begin
            old = ag_reg[way_reg];
            if (st_new.mode == MODE_SRRIP)
            begin
                rr_new[way_reg] = hit_reg ? '0 : RR_FILL;
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (ag_reg[w] < AGE_MAX)
                    begin
                        ag_new[w] = ag_reg[w] + 1'b1;
                    end
                end
            end
            else
            begin
                rr_new[way_reg] = RR_TOP;
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (ag_reg[w] < old)
                    begin
                        ag_new[w] = ag_reg[w] + 1'b1;
                    end
                end
            end
            ag_new[way_reg] = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RST;
            tol_reg     <= TOL_RST;
            thr_reg     <= THR_RST;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PHASE_PERIOD: period_reg <= cfg_data;
                    REG_STRIDE_TOL:   tol_reg    <= cfg_data;
                    REG_HIT_THR:      thr_reg    <= cfg_data[THR_W-1:0];
                    default:          ;
                endcase
            end
            if (dp_cmd.clear_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            cmd_reg    <= cmd;
            set_in_reg <= set_index;
            way_reg    <= way_index;
            addr_reg   <= phys_addr;
            hit_reg    <= was_hit;
        end
        if (dp_cmd.quot)
        begin
            q_reg <= qprod[RCP_SH +: SET_IN_W];
        end
        if (dp_cmd.rd)
        begin
            set_reg <= set_mod;
        end
        if (dp_cmd.exec1)
        begin
            rr_reg   <= rr_rd;
            ag_reg   <= ag_rd;
            st_reg   <= (cmd_reg == CMD_UPDATE) ? st_upd : st_rd;
            m_rr_reg <= m_rr;
            m_ag_reg <= m_ag;
        end
        if (dp_cmd.exec2)
        begin
            spatial_reg <= spatial_next;
            prod_reg    <= prod_next;
            if (cmd_reg == CMD_VICTIM)
            begin
                if (st_reg.mode == MODE_SRRIP)
                begin
                    rr_reg     <= rr_aged;
                    victim_reg <= found ? srrip_v : '0;
                end
                else
                begin
                    victim_reg <= lru_v;
                end
            end
            else
            begin
                victim_reg <= '0;
            end
        end
        if (dp_cmd.exec3 && cmd_reg == CMD_UPDATE)
        begin
            rr_reg <= rr_new;
            ag_reg <= ag_new;
            st_reg <= st_new;
        end
        if (dp_cmd.write)
        begin
            out_victim_reg <= victim_reg;
            out_mode_reg   <= st_reg.mode;
        end
    end

    assign victim_way = out_victim_reg;
    assign set_mode   = out_mode_reg;

endmodule

[tb/psrl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_checker
// predicts victim way and set mode for every accepted request and compares
// them with the result transfers of the replacement block
// ----------------------------------------------------------------------------
module psrl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            cmd,
    input  logic [psrl_pkg::SET_IN_W-1:0]   set_index,
    input  logic [3:0]                      way_index,
    input  logic [psrl_pkg::ADDR_W-1:0]     phys_addr,
    input  logic                            was_hit,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [3:0]                      victim_way,
    input  logic                            set_mode,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              checked,
    output int                              lru_results
);
    import psrl_pkg::*;

    localparam int NSETS = NUM_SETS_DEF;
    localparam int NWAYS = NUM_WAYS_DEF;
    localparam logic [1:0] RRPV_TOP  = 2'd3;
    localparam logic [1:0] RRPV_FILL = 2'd2;

    typedef struct packed {
        logic [3:0] victim;
        logic       mode;
    } outcome_t;

    // predicted metadata of every set
    logic [1:0]        rrpv_tbl  [NSETS][NWAYS];
    logic [3:0]        age_tbl   [NSETS][NWAYS];
    logic              mode_tbl  [NSETS];
    logic [2:0]        warm_tbl  [NSETS];
    logic [15:0]       pcount    [NSETS];
    logic [15:0]       phits     [NSETS];
    logic [ADDR_W-1:0] addr_hist [NSETS][HIST_LEN];
    logic [1:0]        hist_ptr  [NSETS];
    longint            strides   [NSETS][STRIDE_LEN];

    logic [15:0] period;
    logic [15:0] tolerance;
    logic [7:0]  threshold;

    outcome_t expected_q[$];

    initial
    begin
        for (int s = 0; s < NSETS; s++)
        begin
            for (int w = 0; w < NWAYS; w++)
            begin
                rrpv_tbl[s][w] = RRPV_TOP;
                age_tbl[s][w]  = 4'(w);
            end
            mode_tbl[s] = MODE_SRRIP;
            warm_tbl[s] = '0;
            pcount[s]   = '0;
            phits[s]    = '0;
            hist_ptr[s] = '0;
            for (int i = 0; i < HIST_LEN; i++)
                addr_hist[s][i] = '0;
            for (int i = 0; i < STRIDE_LEN; i++)
                strides[s][i] = 0;
        end
        period      = PERIOD_RST;
        tolerance   = TOL_RST;
        threshold   = THR_RST;
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
        lru_results = 0;
    end

    function automatic logic [3:0] choose_victim(int s);
        logic [3:0] best;
        logic [3:0] pick;
        if (mode_tbl[s] == MODE_SRRIP)
        begin
            for (int pass = 0; pass < 2; pass++)
            begin
                for (int w = 0; w < NWAYS; w++)
                    if (rrpv_tbl[s][w] == RRPV_TOP)
                        return 4'(w);
                // no line at the top value: age the whole set
                for (int w = 0; w < NWAYS; w++)
                    if (rrpv_tbl[s][w] < RRPV_TOP)
                        rrpv_tbl[s][w]++;
            end
            return 4'd0;
        end
        best = '0;
        pick = '0;
        for (int w = 0; w < NWAYS; w++)
            if (age_tbl[s][w] >= best)
            begin
                best = age_tbl[s][w];
                pick = 4'(w);
            end
        return pick;
    endfunction

    function automatic void record_access(int s, int way, logic [ADDR_W-1:0] addr,
                                          logic hit);
        int         p;
        longint     step;
        longint     d;
        bit         spatial;
        logic [3:0] old;
        logic [63:0] lhs;
        logic [63:0] rhs;
        p = hist_ptr[s];
        step = longint'({16'b0, addr}) - longint'({16'b0, addr_hist[s][p]});
        spatial = 1'b0;
        if (warm_tbl[s] < WARM_MAX)
            warm_tbl[s]++;
        if (pcount[s] != CNT_MAX)
            pcount[s]++;
        if (hit && phits[s] != CNT_MAX)
            phits[s]++;
        if (p > 0)
            strides[s][p-1] = step;
        addr_hist[s][p] = addr;
        hist_ptr[s] = 2'(p + 1);

        if (warm_tbl[s] >= WARM_MAX)
        begin
            spatial = 1'b1;
            for (int i = 0; i < STRIDE_LEN; i++)
            begin
                d = strides[s][i] - strides[s][0];
                if (d < 0)
                    d = -d;
                if (d > longint'(tolerance))
                    spatial = 1'b0;
            end
        end

        // end of period: pick the mode from this period's hit rate
        if (pcount[s] >= period)
        begin
            lhs = 64'(phits[s]) * 64'd256;
            rhs = 64'(threshold) * 64'(pcount[s]);
            mode_tbl[s] = (spatial && lhs > rhs) ? MODE_SRRIP : MODE_LRU;
            pcount[s] = '0;
            phits[s]  = '0;
        end

        if (way >= NWAYS)
            return;
        if (mode_tbl[s] == MODE_SRRIP)
        begin
            rrpv_tbl[s][way] = hit ? 2'd0 : RRPV_FILL;
            for (int w = 0; w < NWAYS; w++)
                if (age_tbl[s][w] < NWAYS - 1)
                    age_tbl[s][w]++;
            age_tbl[s][way] = '0;
        end
        else
        begin
            old = age_tbl[s][way];
            for (int w = 0; w < NWAYS; w++)
                if (age_tbl[s][w] < old)
                    age_tbl[s][w]++;
            age_tbl[s][way]  = '0;
            rrpv_tbl[s][way] = RRPV_TOP;
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t exp_r;
        int       s;
        if (rst_n)
        begin
            // results first: a result never leaves in the cycle its request arrives
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, victim %0d mode %0d",
                             $time, victim_way, set_mode);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    checked++;
                    if (set_mode == MODE_LRU)
                        lru_results++;
                    if (victim_way !== exp_r.victim)
                    begin
                        mismatches++;
                        $display("%0t: victim_way expected %0d actual %0d",
                                 $time, exp_r.victim, victim_way);
                    end
                    if (set_mode !== exp_r.mode)
                    begin
                        mismatches++;
                        $display("%0t: set_mode expected %0d actual %0d",
                                 $time, exp_r.mode, set_mode);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PHASE_PERIOD: period    = cfg_data;
                    REG_STRIDE_TOL:   tolerance = cfg_data;
                    REG_HIT_THR:      threshold = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                s = int'(set_index) % NSETS;
                exp_r.victim = '0;
                if (cmd == CMD_VICTIM)
                    exp_r.victim = choose_victim(s);
                else
                    record_access(s, int'(way_index), phys_addr, was_hit);
                exp_r.mode = mode_tbl[s];
                expected_q.push_back(exp_r);
            end
            outstanding = expected_q.size();
        end
    end

endmodule

[tb/tb_phase_adaptive_srrip_lru_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phase_adaptive_srrip_lru_replacement
// drives victim requests and access updates through several register
// settings, with random idling on both channels; the checker predicts
// and compares every result
// ----------------------------------------------------------------------------
module tb_phase_adaptive_srrip_lru_replacement;
    import psrl_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cmd = CMD_VICTIM;
    logic [SET_IN_W-1:0]   set_index = '0;
    logic [3:0]            way_index = '0;
    logic [ADDR_W-1:0]     phys_addr = '0;
    logic                  was_hit = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [3:0]            victim_way;
    logic                  set_mode;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int checked;
    int lru_results;

    // idling control: quiet switches it all off for the closing stretch
    bit quiet = 1'b0;
    bit gaps_on = 1'b1;
    int n_victim = 0;
    int n_update = 0;
    int n_settings = 0;
    int stall_left = 0;
    logic [SET_IN_W-1:0] set_pool[4];

    phase_adaptive_srrip_lru_replacement DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .set_index  (set_index),
        .way_index  (way_index),
        .phys_addr  (phys_addr),
        .was_hit    (was_hit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .victim_way (victim_way),
        .set_mode   (set_mode),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    psrl_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .set_index   (set_index),
        .way_index   (way_index),
        .phys_addr   (phys_addr),
        .was_hit     (was_hit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .victim_way  (victim_way),
        .set_mode    (set_mode),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .lru_results (lru_results)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // hard limit, well beyond the slowest correct run including the clearing pass
    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("end of test: mismatches");
        $finish;
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // one request transfer, optionally preceded by an idle burst
    task automatic send_req(logic c, logic [SET_IN_W-1:0] s, logic [3:0] w,
                            logic [ADDR_W-1:0] a, logic h);
        if (!quiet && gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        set_index <= s;
        way_index <= w;
        phys_addr <= a;
        was_hit   <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == CMD_UPDATE)
            n_update++;
        else
            n_victim++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain the pipeline before touching the registers
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_regs(logic [15:0] per, logic [15:0] tol, logic [15:0] thr);
        write_reg(REG_PHASE_PERIOD, per);
        write_reg(REG_STRIDE_TOL, tol);
        write_reg(REG_HIT_THR, thr);
        n_settings++;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom(), $urandom()};
    endfunction

    // mostly strided access runs on a few hot sets, each closed by a victim
    // request; the rest is unstructured traffic over the whole set range
    task automatic random_traffic(int n_items);
        int                  sent;
        int                  run;
        logic [SET_IN_W-1:0] s;
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   stride;
        for (int i = 0; i < 4; i++)
            set_pool[i] = SET_IN_W'($urandom());
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s    = set_pool[$urandom_range(0, 3)];
                base = rand_addr();
                case ($urandom_range(0, 3))
                    0:       stride = ADDR_W'($urandom_range(0, 64));
                    1:       stride = ADDR_W'(-longint'($urandom_range(1, 300)));
                    2:       stride = ADDR_W'($urandom_range(0, 70000));
                    default: stride = rand_addr();
                endcase
                run = $urandom_range(3, 10);
                for (int k = 0; k < run; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        base = base + ADDR_W'($urandom_range(0, 200));
                    send_req(CMD_UPDATE, s, 4'($urandom()), base,
                             $urandom_range(0, 3) != 0);
                    base = base + stride;
                end
                send_req(CMD_VICTIM, s, 4'($urandom()), rand_addr(), 1'($urandom()));
                sent += run + 1;
            end
            else
            begin
                send_req(1'($urandom()), SET_IN_W'($urandom()), 4'($urandom()),
                         rand_addr(), 1'($urandom()));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] a;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: short period so mode changes show up early
        set_regs(16'd4, 16'd64, 16'd64);
        write_reg(2'd3, 16'hFFFF);             // unused index, must be ignored
        send_req(CMD_VICTIM, '0, '0, '0, 1'b0);
        send_req(CMD_VICTIM, '1, 4'hF, '1, 1'b1);   // odd fields ignored
        a = 48'h0000_0000_1000;
        for (int k = 0; k < 8; k++)
        begin
            send_req(CMD_UPDATE, 11'd5, 4'(k * 2 + 1), a, 1'b1);
            a = a + 48'h40;
        end
        send_req(CMD_VICTIM, 11'd5, '0, '0, 1'b0);
        for (int k = 0; k < 5; k++)
            send_req(CMD_UPDATE, 11'd9, 4'(15 - k), (k % 2) ? '1 : '0, 1'b0);
        send_req(CMD_VICTIM, 11'd9, '0, '0, 1'b0);
        send_req(CMD_UPDATE, '1, 4'hF, '1, 1'b1);
        send_req(CMD_VICTIM, '1, '0, '0, 1'b0);
        drain();

        // zero period: every update re-chooses the mode
        set_regs(16'd0, 16'd0, 16'd255);
        for (int k = 0; k < 5; k++)
            send_req(CMD_UPDATE, 11'd77, 4'(k), 48'(k * 8), 1'b1);
        send_req(CMD_VICTIM, 11'd77, '0, '0, 1'b0);
        random_traffic(120);
        drain();

        set_regs(16'd1, 16'hFFFF, 16'd0);
        random_traffic(130);
        drain();

        set_regs(16'hFFFF, 16'hFFFF, 16'd255);
        random_traffic(100);
        drain();

        set_regs(16'd8, 16'd16, 16'd128);
        random_traffic(130);
        drain();

        set_regs(16'($urandom_range(2, 12)), 16'($urandom_range(0, 500)),
                 16'($urandom_range(0, 255)));
        random_traffic(120);
        drain();

        // closing stretch without any idling
        quiet = 1'b1;
        set_regs(16'd3, 16'd64, 16'd64);
        random_traffic(120);
        drain();
        repeat (20) @(posedge clk);

        $display("%0d requests (%0d victim, %0d update) over %0d register settings",
                 n_victim + n_update, n_victim, n_update, n_settings);
        $display("%0d results checked, %0d of them from sets in lru mode",
                 checked, lru_results);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
